// ===== src/ghe_pkg.sv =====
// Shared types, widths and the base32 character table for the geohash encoder.
package ghe_pkg;

  localparam int LON_W = 41;
  localparam int LAT_W = 40;
  localparam int CNT_W = 4;
  localparam int SYM_W = 7;
  localparam int DIG_W = 5;

  // Stage control word that travels beside the interval remainders.
  typedef struct packed {
    logic             valid;
    logic [CNT_W-1:0] count;
  } ghe_ctl_t;

  // First character sits in the top byte of the literal.
  localparam logic [32*8-1:0] ALPHABET = "0123456789bcdefghjkmnpqrstuvwxyz";

  function automatic logic [SYM_W-1:0] ghe_symbol(input logic [DIG_W-1:0] d);
    logic [7:0] pos;
    pos = {~d, 3'b000};
    return ALPHABET[pos +: SYM_W];
  endfunction

endpackage

// ===== src/ghe_intake.sv =====
// Input stage: clamps both coordinates into interval offsets and saturates the count.
module ghe_intake
  import ghe_pkg::*;
#(
  parameter int MAX_CHARS = 12,
  parameter int FRAC_BITS = 32,
  parameter int RW        = FRAC_BITS + 10
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic signed [LON_W-1:0] longitude,
  input  logic signed [LAT_W-1:0] latitude,
  input  logic [CNT_W-1:0]        char_count,
  output ghe_ctl_t                ctl,
  output logic [RW-1:0]           lon_r,
  output logic [RW-1:0]           lat_r
);

  localparam int EWO = ((LON_W > RW) ? LON_W : RW) + 2;
  localparam int EWA = ((LAT_W > RW) ? LAT_W : RW) + 2;
  localparam logic [RW-1:0] LON_HALF = RW'(180) << FRAC_BITS;
  localparam logic [RW-1:0] LAT_HALF = RW'(90) << FRAC_BITS;
  localparam logic signed [EWO-1:0] LON_HALF_S = signed'(EWO'(LON_HALF));
  localparam logic signed [EWA-1:0] LAT_HALF_S = signed'(EWA'(LAT_HALF));

  logic signed [EWO-1:0] lon_sum;
  logic signed [EWA-1:0] lat_sum;
  logic [RW-1:0]         lon_off;
  logic [RW-1:0]         lat_off;
  logic [CNT_W-1:0]      cnt_sat;

  // offset = coordinate + half span, clamped to [0, span]
  always_comb begin
    lon_sum = EWO'(longitude) + LON_HALF_S;
    lat_sum = EWA'(latitude) + LAT_HALF_S;
    if (lon_sum[EWO-1]) begin
      lon_off = '0;
    end else if (lon_sum >= (LON_HALF_S <<< 1)) begin
      lon_off = LON_HALF << 1;
    end else begin
      lon_off = lon_sum[RW-1:0];
    end
    if (lat_sum[EWA-1]) begin
      lat_off = '0;
    end else if (lat_sum >= (LAT_HALF_S <<< 1)) begin
      lat_off = LAT_HALF << 1;
    end else begin
      lat_off = lat_sum[RW-1:0];
    end
    cnt_sat = (char_count > CNT_W'(MAX_CHARS)) ? CNT_W'(MAX_CHARS) : char_count;
  end

  // Only the valid bit is reset; payload just follows the enable.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else if (en) begin
      ctl.valid <= in_valid;
    end
    if (en) begin
      ctl.count <= cnt_sat;
      lon_r     <= lon_off;
      lat_r     <= lat_off;
    end
  end

endmodule

// ===== src/ghe_char_stage.sv =====
// One pipeline stage: five bisection steps that produce character IDX.
module ghe_char_stage
  import ghe_pkg::*;
#(
  parameter int MAX_CHARS = 12,
  parameter int FRAC_BITS = 32,
  parameter int RW        = FRAC_BITS + 10,
  parameter int IDX       = 0
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  ghe_ctl_t                            ctl_in,
  input  logic [RW-1:0]                       lon_in,
  input  logic [RW-1:0]                       lat_in,
  input  logic [MAX_CHARS-1:0][DIG_W-1:0]     digits_in,
  output ghe_ctl_t                            ctl_out,
  output logic [RW-1:0]                       lon_out,
  output logic [RW-1:0]                       lat_out,
  output logic [MAX_CHARS-1:0][DIG_W-1:0]     digits_out
);

  localparam logic [RW-1:0] LON_SPAN = RW'(360) << FRAC_BITS;
  localparam logic [RW-1:0] LAT_SPAN = RW'(180) << FRAC_BITS;

  logic [RW-1:0]                   lon_w;
  logic [RW-1:0]                   lat_w;
  logic [RW-1:0]                   sh;
  logic                            bitv;
  logic [DIG_W-1:0]                d;
  logic [MAX_CHARS-1:0][DIG_W-1:0] digits_next;

  // Restoring long division step per bit; axes alternate, longitude on even bits.
  always_comb begin
    lon_w = lon_in;
    lat_w = lat_in;
    d     = '0;
    sh    = '0;
    bitv  = 1'b0;
    for (int b = 0; b < DIG_W; b++) begin
      if (((IDX * DIG_W + b) & 1) == 0) begin
        sh    = {lon_w[RW-2:0], 1'b0};
        bitv  = (sh >= LON_SPAN);
        lon_w = bitv ? sh - LON_SPAN : sh;
      end else begin
        sh    = {lat_w[RW-2:0], 1'b0};
        bitv  = (sh >= LAT_SPAN);
        lat_w = bitv ? sh - LAT_SPAN : sh;
      end
      d = {d[DIG_W-2:0], bitv};
    end
    digits_next      = digits_in;
    digits_next[IDX] = d;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else if (en) begin
      ctl_out.valid <= ctl_in.valid;
    end
    if (en) begin
      ctl_out.count <= ctl_in.count;
      lon_out       <= lon_w;
      lat_out       <= lat_w;
      digits_out    <= digits_next;
    end
  end

endmodule

// ===== src/ghe_serializer.sv =====
// Output stage: emits the digits of one point one character per cycle while char_ready is high.
module ghe_serializer
  import ghe_pkg::*;
#(
  parameter int MAX_CHARS = 12
) (
  input  logic                            clk,
  input  logic                            rst,
  input  ghe_ctl_t                        ctl_in,
  input  logic [MAX_CHARS-1:0][DIG_W-1:0] digits_in,
  output logic                            take,
  output logic                            char_valid,
  input  logic                            char_ready,
  output logic [SYM_W-1:0]                symbol,
  output logic [DIG_W-1:0]                digit,
  output logic                            last
);

  logic                            busy;
  logic [CNT_W-1:0]                rem;
  logic [MAX_CHARS-1:0][DIG_W-1:0] dig;
  logic                            final_go;

  assign final_go   = busy && char_ready && (rem == CNT_W'(1));
  assign take       = ctl_in.valid && (!busy || final_go);
  assign char_valid = busy;
  assign digit      = dig[0];
  assign symbol     = ghe_symbol(dig[0]);
  assign last       = (rem == CNT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (take) begin
      busy <= (ctl_in.count != '0);
    end else if (final_go) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rem <= ctl_in.count;
      dig <= digits_in;
    end else if (busy && char_ready) begin
      rem <= rem - CNT_W'(1);
      dig <= dig >> DIG_W;
    end
  end

endmodule

// ===== src/geohash_encoder_top.sv =====
// Geohash encoder top level: intake, one bisection stage per character, serializer.
// A point passes the intake and each stage register before its first character is valid.
// Throughput: the serializer, at one character per cycle while char_ready is high, sets
//   the pace and stalls the whole pipeline behind it.
// Reset (rst, synchronous): clears all stage valid bits and the serializer; no
//   request is in flight afterwards. Payload registers are not reset.
module geohash_encoder_top
  import ghe_pkg::*;
#(
  parameter int MAX_CHARS = 12,
  parameter int FRAC_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    point_valid,
  output logic                    point_ready,
  input  logic signed [LON_W-1:0] longitude,
  input  logic signed [LAT_W-1:0] latitude,
  input  logic [CNT_W-1:0]        char_count,
  output logic                    char_valid,
  input  logic                    char_ready,
  output logic [SYM_W-1:0]        symbol,
  output logic [DIG_W-1:0]        digit,
  output logic                    last
);

  // Offsets reach twice the span after the shift, so F + 10 bits are enough.
  localparam int RW = FRAC_BITS + 10;

  // Stage k holds the remainders after k characters and digits 0..k-1.
  ghe_ctl_t                        ctl_p    [MAX_CHARS+1];
  logic [RW-1:0]                   lon_p    [MAX_CHARS+1];
  logic [RW-1:0]                   lat_p    [MAX_CHARS+1];
  logic [MAX_CHARS-1:0][DIG_W-1:0] digits_p [MAX_CHARS+1];

  logic adv;
  logic take;

  // Whole pipeline moves together; it holds only when the final stage has a
  // request the serializer cannot take yet.
  assign adv         = !ctl_p[MAX_CHARS].valid || take;
  assign point_ready = adv;

  ghe_intake #(
    .MAX_CHARS (MAX_CHARS),
    .FRAC_BITS (FRAC_BITS),
    .RW        (RW)
  ) u_intake (
    .clk        (clk),
    .rst        (rst),
    .en         (adv),
    .in_valid   (point_valid),
    .longitude  (longitude),
    .latitude   (latitude),
    .char_count (char_count),
    .ctl        (ctl_p[0]),
    .lon_r      (lon_p[0]),
    .lat_r      (lat_p[0])
  );

  assign digits_p[0] = '0;

  for (genvar k = 0; k < MAX_CHARS; k++) begin : g_stage
    ghe_char_stage #(
      .MAX_CHARS (MAX_CHARS),
      .FRAC_BITS (FRAC_BITS),
      .RW        (RW),
      .IDX       (k)
    ) u_stage (
      .clk        (clk),
      .rst        (rst),
      .en         (adv),
      .ctl_in     (ctl_p[k]),
      .lon_in     (lon_p[k]),
      .lat_in     (lat_p[k]),
      .digits_in  (digits_p[k]),
      .ctl_out    (ctl_p[k+1]),
      .lon_out    (lon_p[k+1]),
      .lat_out    (lat_p[k+1]),
      .digits_out (digits_p[k+1])
    );
  end

  // Zero-count requests are taken here and simply produce nothing.
  ghe_serializer #(
    .MAX_CHARS (MAX_CHARS)
  ) u_serializer (
    .clk        (clk),
    .rst        (rst),
    .ctl_in     (ctl_p[MAX_CHARS]),
    .digits_in  (digits_p[MAX_CHARS]),
    .take       (take),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .symbol     (symbol),
    .digit      (digit),
    .last       (last)
  );

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the geohash encoder: scoreboard class, drivers and top module.
`timescale 1ns / 1ps

// One predicted geohash character.
typedef struct {
  logic [ghe_pkg::SYM_W-1:0] symbol;
  logic [ghe_pkg::DIG_W-1:0] digit;
  logic                      last;
} geo_char_t;

// Scoreboard: predicts the characters of each accepted point request and
// checks every character the encoder hands out against the oldest one pending.
class geohash_scoreboard;
  localparam int  FRAC      = 32;
  localparam int  CHAR_MAX  = 12;
  localparam longint LON_HALF = longint'(180) << FRAC;
  localparam longint LAT_HALF = longint'(90) << FRAC;

  string     base32 = "0123456789bcdefghjkmnpqrstuvwxyz";
  geo_char_t pending_chars[$];
  int        mismatches;
  int        points_taken;
  int        chars_checked;

  // Offset of a coordinate from the low end of its axis, clamped to the axis.
  function longint axis_offset(longint coord, longint half);
    if (coord < -half) return 0;
    if (coord >= half) return half << 1;
    return coord + half;
  endfunction

  // Bisect both intervals and queue the characters this point produces.
  function void note_point(longint lon, longint lat, logic [3:0] cnt);
    longint    lon_rem;
    longint    lat_rem;
    bit        lon_turn;
    int        n_chars;
    logic [4:0] dig;
    geo_char_t ch;
    lon_rem  = axis_offset(lon, LON_HALF);
    lat_rem  = axis_offset(lat, LAT_HALF);
    lon_turn = 1'b1;
    n_chars  = (cnt > CHAR_MAX) ? CHAR_MAX : int'(cnt);
    points_taken++;
    for (int c = 0; c < n_chars; c++) begin
      dig = '0;
      for (int b = 0; b < 5; b++) begin
        if (lon_turn) begin
          lon_rem = lon_rem << 1;
          dig     = {dig[3:0], lon_rem >= (LON_HALF << 1)};
          if (dig[0]) lon_rem -= LON_HALF << 1;
        end else begin
          lat_rem = lat_rem << 1;
          dig     = {dig[3:0], lat_rem >= (LAT_HALF << 1)};
          if (dig[0]) lat_rem -= LAT_HALF << 1;
        end
        lon_turn = !lon_turn;
      end
      ch.symbol = 7'(base32[dig]);
      ch.digit  = dig;
      ch.last   = (c == n_chars - 1);
      pending_chars.push_back(ch);
    end
  endfunction

  function void check_char(logic [6:0] sym, logic [4:0] dig, logic lst);
    geo_char_t want;
    chars_checked++;
    if (pending_chars.size() == 0) begin
      $error("unexpected character: symbol %0d digit %0d last %0d", sym, dig, lst);
      mismatches++;
      return;
    end
    want = pending_chars.pop_front();
    if (sym !== want.symbol) begin
      $error("symbol mismatch: expected %0d, actual %0d", want.symbol, sym);
      mismatches++;
    end
    if (dig !== want.digit) begin
      $error("digit mismatch: expected %0d, actual %0d", want.digit, dig);
      mismatches++;
    end
    if (lst !== want.last) begin
      $error("last mismatch: expected %0d, actual %0d", want.last, lst);
      mismatches++;
    end
  endfunction
endclass

module tb_top;
  import ghe_pkg::*;

  localparam int     MAX_CHARS   = 12;
  localparam int     DRAIN_WAIT  = 4 * (MAX_CHARS + 2);
  localparam int     CYCLE_LIMIT = 400000;
  localparam int     RAND_POINTS = 120;   // per pacing phase, four phases
  localparam longint LON_HALF    = longint'(180) << 32;
  localparam longint LAT_HALF    = longint'(90) << 32;
  localparam longint LON_MIN     = -(longint'(1) << (LON_W - 1));
  localparam longint LON_MAX     = (longint'(1) << (LON_W - 1)) - 1;
  localparam longint LAT_MIN     = -(longint'(1) << (LAT_W - 1));
  localparam longint LAT_MAX     = (longint'(1) << (LAT_W - 1)) - 1;

  logic                    clk         = 1'b0;
  logic                    rst         = 1'b1;
  logic                    point_valid = 1'b0;
  logic                    point_ready;
  logic signed [LON_W-1:0] longitude   = '0;
  logic signed [LAT_W-1:0] latitude    = '0;
  logic [CNT_W-1:0]        char_count  = '0;
  logic                    char_valid;
  logic                    char_ready  = 1'b0;
  logic [SYM_W-1:0]        symbol;
  logic [DIG_W-1:0]        digit;
  logic                    last;

  // Pacing knobs, in percent of cycles.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int cycle_cnt      = 0;

  geohash_scoreboard sb = new();

  geohash_encoder_top #(.MAX_CHARS(MAX_CHARS), .FRAC_BITS(32)) dut (
    .clk        (clk),
    .rst        (rst),
    .point_valid(point_valid),
    .point_ready(point_ready),
    .longitude  (longitude),
    .latitude   (latitude),
    .char_count (char_count),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .symbol     (symbol),
    .digit      (digit),
    .last       (last)
  );

  always #10 clk = ~clk;

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver back-pressure, redrawn every cycle.
  always @(posedge clk) begin
    char_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Output monitor: values read here are the ones present at the edge.
  always @(posedge clk) begin
    if (!rst && char_valid && char_ready) sb.check_char(symbol, digit, last);
  end

  // Drive one point request. Valid is only dropped when a gap is taken, so a
  // back-to-back request never sees valid lowered and raised in one step.
  task automatic send_point(longint lon, longint lat, logic [3:0] cnt);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      point_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    point_valid <= 1'b1;
    longitude   <= lon[LON_W-1:0];
    latitude    <= lat[LAT_W-1:0];
    char_count  <= cnt;
    do @(posedge clk); while (!point_ready);
    sb.note_point(lon, lat, cnt);
  endtask

  // Random coordinate: mostly in range, some full-width raw values, some on
  // or next to a bisection midpoint, some right at the axis bounds.
  function automatic longint rand_coord(longint half, int w);
    bit [63:0] r64;
    int        sel;
    int        n;
    longint    k;
    r64 = {$urandom, $urandom};
    sel = $urandom_range(0, 99);
    if (sel < 55) return longint'(r64 % ((half << 1) + 1)) - half;
    if (sel < 75) return longint'(r64 << (64 - w)) >>> (64 - w);
    if (sel < 92) begin
      n = $urandom_range(1, 30);
      k = longint'(r64 % ((64'd1 << n) + 1));
      return -half + ((half << 1) >>> n) * k + $urandom_range(0, 2) - 1;
    end
    case ($urandom_range(0, 5))
      0:       return -half - 1;
      1:       return -half;
      2:       return -half + 1;
      3:       return half - 1;
      4:       return half;
      default: return half + 1;
    endcase
  endfunction

  // Counts: mostly legal lengths, with zero and saturating values mixed in.
  function automatic logic [3:0] rand_count();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 10) return 4'd0;
    if (sel < 20) return 4'($urandom_range(13, 15));
    return 4'($urandom_range(1, 12));
  endfunction

  task automatic run_directed();
    send_point(0, 0, 4'd12);                          // both on the first midpoint
    send_point(-1, -1, 4'd12);                        // just below it
    send_point(LON_MIN, LAT_MIN, 4'd12);              // most negative codes, clamp low
    send_point(LON_MAX, LAT_MAX, 4'd12);              // most positive codes, clamp high
    send_point(-LON_HALF, -LAT_HALF, 4'd12);          // exactly on the lower bounds
    send_point(LON_HALF, LAT_HALF, 4'd12);            // exactly on the upper bounds
    send_point(LON_HALF - 1, LAT_HALF - 1, 4'd12);    // one unit under the top
    send_point(-LON_HALF - 1, -LAT_HALF - 1, 4'd12);  // one unit under the bottom
    send_point(-LON_HALF + 1, -LAT_HALF + 1, 4'd12);
    send_point(LON_HALF + 1, -LAT_HALF - 1, 4'd7);    // mixed clamps
    send_point(LON_MIN, LAT_MAX, 4'd3);
    send_point(LON_HALF >>> 1, -(LAT_HALF >>> 1), 4'd5);
    send_point(12345678901, -9876543210, 4'd0);       // zero count: nothing comes out
    send_point(0, 0, 4'd0);
    send_point(-5000000000, 3000000000, 4'd1);        // single character, last set
    send_point(700000000000, 300000000000, 4'd13);    // above the maximum: saturates
    send_point(-700000000000, -300000000000, 4'd15);
    send_point(LON_MAX, LAT_MIN, 4'd15);
    send_point(0, 0, 4'd0);
    send_point(1, 1, 4'd2);
  endtask

  task automatic run_random(int sender_pct, int receiver_pct);
    send_idle_pct  = sender_pct;
    recv_stall_pct = receiver_pct;
    repeat (RAND_POINTS) begin
      send_point(rand_coord(LON_HALF, LON_W), rand_coord(LAT_HALF, LAT_W), rand_count());
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();
    run_random(0, 0);      // full rate on both sides
    run_random(78, 0);     // sparse requests
    run_random(0, 78);     // heavy back-pressure
    run_random(38, 38);    // both sides uneven
    point_valid   <= 1'b0;
    recv_stall_pct = 0;

    // Drain, then give the pipeline time to show any stray character.
    while (sb.pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Covered %0d point requests and %0d characters under four pacing mixes.",
             sb.points_taken, sb.chars_checked);
    if (sb.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
